FILE: rtl/rc4_pkg.sv
package rc4_pkg;

	// Key storage: four 64-bit words, 32 key bytes in total
	localparam int KEY_WORDS     = 4;
	localparam int KEY_WORD_W    = 64;
	localparam int KEY_BYTES     = KEY_WORDS * KEY_WORD_W / 8;
	localparam int MAX_KEY_BYTES = 32;
	localparam int POS_W         = $clog2(KEY_BYTES);
	localparam int LEN_W         = 6;
	localparam int CFG_IDX_W     = 3;

	typedef logic [7:0] byte_t;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 3'd4;

	// Program addresses of the microcode
	typedef logic [3:0] pc_t;
	localparam pc_t PC_IDLE = 4'd0;
	localparam pc_t PC_D0   = 4'd1;
	localparam pc_t PC_D1   = 4'd2;
	localparam pc_t PC_D2   = 4'd3;
	localparam pc_t PC_D3   = 4'd4;
	localparam pc_t PC_K0   = 4'd5;
	localparam pc_t PC_K1   = 4'd6;
	localparam pc_t PC_K2   = 4'd7;
	localparam pc_t PC_K3   = 4'd8;

	// Table address sources
	typedef enum logic [2:0] {
		A_I    = 3'd0,
		A_K    = 3'd1,
		A_JNEW = 3'd2,
		A_SUM  = 3'd3,
		A_J    = 3'd4
	} addr_sel_t;

	// Table write data sources
	typedef enum logic {
		D_RD = 1'b0,
		D_SI = 1'b1
	} data_sel_t;

	// Sequencer operations
	typedef enum logic [1:0] {
		OP_NEXT     = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_HOLD_OUT = 2'd2,
		OP_LOOP_K   = 2'd3
	} seq_op_t;

	typedef struct packed {
		seq_op_t   op;
		pc_t       next_pc;
		logic      rd_en;
		addr_sel_t rd_addr;
		logic      wr_en;
		addr_sel_t wr_addr;
		data_sel_t wr_data;
		logic      add_key;
		logic      step_j;
		logic      latch_sj;
		logic      emit;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctrl;
		logic  start_data;
		logic  start_key;
		logic  advance;
	} seq_cmd_t;

	typedef struct packed {
		logic k_last;
		logic out_busy;
	} dp_status_t;

	// Control store: one word per step
	function automatic ctrl_t ucode(pc_t pc);
		ctrl_t w;
		w = '{op: OP_DISPATCH, next_pc: PC_IDLE, rd_en: 1'b0, rd_addr: A_I,
			wr_en: 1'b0, wr_addr: A_I, wr_data: D_RD, add_key: 1'b0,
			step_j: 1'b0, latch_sj: 1'b0, emit: 1'b0};
		case (pc)
			PC_IDLE: begin
				w.op = OP_DISPATCH;
			end
			// Generator step: read S[i]
			PC_D0: begin
				w.op = OP_NEXT; w.next_pc = PC_D1;
				w.rd_en = 1'b1; w.rd_addr = A_I;
			end
			// j += S[i], read S[j]
			PC_D1: begin
				w.op = OP_NEXT; w.next_pc = PC_D2;
				w.rd_en = 1'b1; w.rd_addr = A_JNEW; w.step_j = 1'b1;
			end
			// S[i] = S[j], read S[S[i]+S[j]]
			PC_D2: begin
				w.op = OP_NEXT; w.next_pc = PC_D3;
				w.rd_en = 1'b1; w.rd_addr = A_SUM;
				w.wr_en = 1'b1; w.wr_addr = A_I; w.wr_data = D_RD;
				w.latch_sj = 1'b1;
			end
			// S[j] = old S[i], emit the word
			PC_D3: begin
				w.op = OP_HOLD_OUT; w.next_pc = PC_IDLE;
				w.wr_en = 1'b1; w.wr_addr = A_J; w.wr_data = D_SI;
				w.emit = 1'b1;
			end
			// Key schedule: read S[k]
			PC_K0: begin
				w.op = OP_NEXT; w.next_pc = PC_K1;
				w.rd_en = 1'b1; w.rd_addr = A_K;
			end
			// j += S[k] + key byte, read S[j]
			PC_K1: begin
				w.op = OP_NEXT; w.next_pc = PC_K2;
				w.rd_en = 1'b1; w.rd_addr = A_JNEW; w.add_key = 1'b1; w.step_j = 1'b1;
			end
			// S[k] = S[j]
			PC_K2: begin
				w.op = OP_NEXT; w.next_pc = PC_K3;
				w.wr_en = 1'b1; w.wr_addr = A_K; w.wr_data = D_RD;
			end
			// S[j] = old S[k], loop over k
			PC_K3: begin
				w.op = OP_LOOP_K; w.next_pc = PC_K0;
				w.wr_en = 1'b1; w.wr_addr = A_J; w.wr_data = D_SI;
			end
			default: begin
				w.op = OP_DISPATCH;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/rc4_seq.sv
module rc4_seq import rc4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       cmd,
	input  dp_status_t status,
	output logic       in_ready,
	output seq_cmd_t   sc
);

	pc_t   pc_q;
	pc_t   pc_next;
	ctrl_t ctrl;
	logic  advance;

	assign ctrl = ucode(pc_q);

	// Pick the next step from the control word and the datapath status
	always_comb begin
		pc_next = pc_q;
		advance = 1'b0;
		unique case (ctrl.op)
			OP_NEXT: begin
				advance = 1'b1;
				pc_next = ctrl.next_pc;
			end
			OP_DISPATCH: begin
				if (in_valid) begin
					advance = 1'b1;
					pc_next = cmd ? PC_D0 : PC_K0;
				end
			end
			OP_HOLD_OUT: begin
				if (!status.out_busy) begin
					advance = 1'b1;
					pc_next = ctrl.next_pc;
				end
			end
			OP_LOOP_K: begin
				advance = 1'b1;
				pc_next = status.k_last ? PC_IDLE : ctrl.next_pc;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign in_ready      = (ctrl.op == OP_DISPATCH);
	assign sc.ctrl       = ctrl;
	assign sc.advance    = advance;
	assign sc.start_data = in_ready && in_valid && cmd;
	assign sc.start_key  = in_ready && in_valid && !cmd;

endmodule

FILE: rtl/rc4_dp.sv
module rc4_dp import rc4_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  seq_cmd_t                    sc,
	input  byte_t                       data_byte,
	input  logic [KEY_BYTES-1:0][7:0]   key_bytes,
	input  logic [LEN_W-1:0]            len_eff,
	input  logic                        out_ready,
	output logic                        out_valid,
	output byte_t                       out_byte,
	output dp_status_t                  status
);

	byte_t            mem_q [256];
	logic [255:0]     valid_q;
	byte_t            rdata_q;
	byte_t            raddr_q;
	logic             rvalid_q;

	byte_t            i_q;
	byte_t            j_q;
	byte_t            k_q;
	logic [POS_W-1:0] pos_q;
	byte_t            si_q;
	byte_t            sj_q;
	byte_t            din_q;
	logic             out_valid_q;
	byte_t            out_byte_q;

	byte_t            rdata_eff;
	byte_t            key_b;
	byte_t            j_new;
	byte_t            raddr;
	byte_t            waddr;
	byte_t            wdata;
	byte_t            ks;
	logic [POS_W-1:0] pos_next;

	// Entries never written since the last rekey hold their own index
	assign rdata_eff = rvalid_q ? rdata_q : raddr_q;
	assign key_b     = sc.ctrl.add_key ? key_bytes[pos_q] : 8'd0;
	assign j_new     = j_q + rdata_eff + key_b;

	always_comb begin
		unique case (sc.ctrl.rd_addr)
			A_I:     raddr = i_q;
			A_K:     raddr = k_q;
			A_JNEW:  raddr = j_new;
			A_SUM:   raddr = si_q + rdata_eff;
			A_J:     raddr = j_q;
			default: raddr = i_q;
		endcase
		unique case (sc.ctrl.wr_addr)
			A_I:     waddr = i_q;
			A_K:     waddr = k_q;
			A_JNEW:  waddr = j_new;
			A_SUM:   waddr = si_q + rdata_eff;
			A_J:     waddr = j_q;
			default: waddr = i_q;
		endcase
		unique case (sc.ctrl.wr_data)
			D_RD: wdata = rdata_eff;
			D_SI: wdata = si_q;
		endcase
	end

	// Forward the swapped values: the keystream read overlapped the writes
	always_comb begin
		if (raddr_q == i_q) begin
			ks = sj_q;
		end else if (raddr_q == j_q) begin
			ks = si_q;
		end else begin
			ks = rdata_eff;
		end
	end

	// Cycle through the key bytes
	always_comb begin
		if (({1'b0, pos_q} + 1'b1) >= len_eff) begin
			pos_next = '0;
		end else begin
			pos_next = pos_q + 1'b1;
		end
	end

	// Permutation table, read data registered
	always_ff @(posedge clk) begin
		if (sc.ctrl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (sc.ctrl.rd_en) begin
			rdata_q  <= mem_q[raddr];
			rvalid_q <= valid_q[raddr];
			raddr_q  <= raddr;
		end
	end

	// Drop all valid bits on rekey: the table reads as the identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (sc.start_key) begin
			valid_q <= '0;
		end else if (sc.ctrl.wr_en) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Indices and key position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
			pos_q <= '0;
		end else begin
			if (sc.start_key) begin
				j_q   <= '0;
				k_q   <= '0;
				pos_q <= '0;
			end
			if (sc.start_data) begin
				i_q <= i_q + 8'd1;
			end
			if (sc.ctrl.step_j) begin
				j_q <= j_new;
			end
			if (sc.ctrl.op == OP_LOOP_K) begin
				if (status.k_last) begin
					i_q <= '0;
					j_q <= '0;
				end else begin
					k_q   <= k_q + 8'd1;
					pos_q <= pos_next;
				end
			end
		end
	end

	// Hold operands of the swap
	always_ff @(posedge clk) begin
		if (sc.start_data) begin
			din_q <= data_byte;
		end
		if (sc.ctrl.step_j) begin
			si_q <= rdata_eff;
		end
		if (sc.ctrl.latch_sj) begin
			sj_q <= rdata_eff;
		end
		if (sc.ctrl.emit && sc.advance) begin
			out_byte_q <= din_q ^ ks;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sc.ctrl.emit && sc.advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign status.k_last   = (k_q == 8'hFF);
	assign status.out_busy = out_valid_q && !out_ready;

endmodule

FILE: rtl/rc4_stream_cipher_unit.sv
// RC4 stream cipher. Write the key words (indexes 0 to 3, byte n of the key in bits
// 8n+7..8n) and the key length (index 4, 0 counts as 1, above 32 as 32), then send a
// word with cmd 0 to run the key schedule; it returns no result, and the next word
// is taken only after four table steps for each of the 256 swaps. Each word with
// cmd 1 returns data_byte XOR the next keystream byte through four steps after its
// acceptance, set by the one read and one write port of the permutation table.
// Encryption and decryption are the same. A result waits in an output register; a
// new word is accepted while it waits, and the following result holds until it is
// taken. Key writes take effect at the next rekey; before any rekey the generator
// runs from the identity table. There is no clearing pass after reset.
module rc4_stream_cipher_unit import rc4_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [7:0]           data_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key_q;
	logic [LEN_W-1:0]                     key_len_q;
	logic [KEY_BYTES-1:0][7:0]            key_bytes;
	logic [LEN_W-1:0]                     len_eff;
	seq_cmd_t                             sc;
	dp_status_t                           status;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			key_len_q <= LEN_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_WORD0: key_q[0]  <= cfg_data;
				CFG_KEY_WORD1: key_q[1]  <= cfg_data;
				CFG_KEY_WORD2: key_q[2]  <= cfg_data;
				CFG_KEY_WORD3: key_q[3]  <= cfg_data;
				CFG_KEY_LEN:   key_len_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Split the key words into bytes
	always_comb begin
		for (int n = 0; n < KEY_BYTES; n++) begin
			key_bytes[n] = key_q[n / 8][(n % 8) * 8 +: 8];
		end
	end

	// Clamp the key length
	always_comb begin
		if (key_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (key_len_q > LEN_W'(MAX_KEY_BYTES)) begin
			len_eff = LEN_W'(MAX_KEY_BYTES);
		end else begin
			len_eff = key_len_q;
		end
	end

	rc4_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.status   (status),
		.in_ready (in_ready),
		.sc       (sc)
	);

	rc4_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.sc        (sc),
		.data_byte (data_byte),
		.key_bytes (key_bytes),
		.len_eff   (len_eff),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.status    (status)
	);

	// A rekey never produces a result
	a_rekey_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !cmd |=> !$rose(out_valid))
		else $error("result raised after a rekey word");

	// A data word keeps the input side closed while it works
	a_data_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd |=> !in_ready)
		else $error("input accepted during a generator step");

	// A result appears only after the sequencer has left idle
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while idle");

endmodule
